[rtl/gtpc_pkg.sv]
package gtpc_pkg;

    // widths of the stored integral and of the datapath
    localparam int INTEGRAL_BITS = 24;
    localparam int HEAD_W        = 16;
    localparam int TIME_W        = 16;
    localparam int GAIN_W        = 12;
    localparam int LIM_W         = 15;
    localparam int ERR_W         = HEAD_W + 1;
    localparam int DIFF_W        = ERR_W + 1;
    localparam int INT_W         = INTEGRAL_BITS;
    localparam int INT_SUM_W     = ((INT_W > ERR_W) ? INT_W : ERR_W) + 1;
    localparam int P_W           = ERR_W + GAIN_W + 1;
    localparam int I_W           = INT_W + GAIN_W + 1;
    localparam int D_W           = DIFF_W + GAIN_W + 1;
    localparam int ACC_W         = ((I_W > D_W) ? I_W : D_W) + 2;
    localparam int FRAC_W        = 8;
    localparam int Q_W           = ACC_W - FRAC_W;
    localparam int DRIVE_W       = 8;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEADING = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_ZONE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_CAP   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_TOLERANCE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_LIMIT_MS  = 3'd7;

    localparam logic signed [HEAD_W-1:0] RST_TARGET_HEADING = 16'sd0;
    localparam logic [GAIN_W-1:0]        RST_GAIN_P         = 12'd13;
    localparam logic [GAIN_W-1:0]        RST_GAIN_I         = 12'd18;
    localparam logic [GAIN_W-1:0]        RST_GAIN_D         = 12'd1024;
    localparam logic [LIM_W-1:0]         RST_INTEGRAL_ZONE  = 15'd100;
    localparam logic [LIM_W-1:0]         RST_INTEGRAL_CAP   = 15'd30;
    localparam logic [LIM_W-1:0]         RST_STOP_TOLERANCE = 15'd15;
    localparam logic [TIME_W-1:0]        RST_TIME_LIMIT_MS  = 16'd2000;

    typedef struct packed {
        logic signed [HEAD_W-1:0] target_heading;
        logic [GAIN_W-1:0]        gain_p;
        logic [GAIN_W-1:0]        gain_i;
        logic [GAIN_W-1:0]        gain_d;
        logic [LIM_W-1:0]         integral_zone;
        logic [LIM_W-1:0]         integral_cap;
        logic [LIM_W-1:0]         stop_tolerance;
        logic [TIME_W-1:0]        time_limit_ms;
    } t_cfg;

    typedef struct packed {
        logic signed [HEAD_W-1:0] heading_sample;
        logic [TIME_W-1:0]        elapsed_ms;
    } t_in;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] left_drive;
        logic signed [DRIVE_W-1:0] right_drive;
        logic                      finished;
    } t_out;

    // stage enables of the pipeline
    typedef struct packed {
        logic take;
        logic s1;
        logic s2;
        logic s3;
        logic out;
    } t_pipe_en;

    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [INT_W-1:0]  integ;
        logic signed [DIFF_W-1:0] diff;
        logic                     done;
    } t_term;

endpackage

[rtl/gtpc_cfg.sv]
module gtpc_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gtpc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gtpc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output gtpc_pkg::t_cfg                    o_cfg
);
    import gtpc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_heading <= RST_TARGET_HEADING;
            r_cfg.gain_p         <= RST_GAIN_P;
            r_cfg.gain_i         <= RST_GAIN_I;
            r_cfg.gain_d         <= RST_GAIN_D;
            r_cfg.integral_zone  <= RST_INTEGRAL_ZONE;
            r_cfg.integral_cap   <= RST_INTEGRAL_CAP;
            r_cfg.stop_tolerance <= RST_STOP_TOLERANCE;
            r_cfg.time_limit_ms  <= RST_TIME_LIMIT_MS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TARGET_HEADING: r_cfg.target_heading <= $signed(i_cfg_data[HEAD_W-1:0]);
                CFG_GAIN_P:         r_cfg.gain_p         <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:         r_cfg.gain_i         <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:         r_cfg.gain_d         <= i_cfg_data[GAIN_W-1:0];
                CFG_INTEGRAL_ZONE:  r_cfg.integral_zone  <= i_cfg_data[LIM_W-1:0];
                CFG_INTEGRAL_CAP:   r_cfg.integral_cap   <= i_cfg_data[LIM_W-1:0];
                CFG_STOP_TOLERANCE: r_cfg.stop_tolerance <= i_cfg_data[LIM_W-1:0];
                CFG_TIME_LIMIT_MS:  r_cfg.time_limit_ms  <= i_cfg_data[TIME_W-1:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/gtpc_front.sv]
module gtpc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gtpc_pkg::t_cfg     i_cfg,
    input  gtpc_pkg::t_in      i_in,
    input  gtpc_pkg::t_pipe_en i_en,
    output gtpc_pkg::t_term    o_term
);
    import gtpc_pkg::*;

    logic signed [INT_W-1:0] r_integral;
    logic signed [ERR_W-1:0] r_prev_err;
    logic                    r_done;
    t_term                   r_term;

    logic signed [ERR_W-1:0]     err;
    logic [ERR_W-1:0]            mag;
    logic                        done_now;
    logic signed [INT_SUM_W-1:0] int_sum;
    logic signed [INT_SUM_W-1:0] int_max;
    logic signed [INT_SUM_W-1:0] int_min;
    logic signed [INT_W-1:0]     int_sat;
    logic signed [INT_W-1:0]     cap_ext;
    logic signed [INT_W-1:0]     n_integral;
    t_term                       n_term;

    always_comb begin
        err = ERR_W'(i_cfg.target_heading) - ERR_W'(i_in.heading_sample);
        mag = err[ERR_W-1] ? ERR_W'(-err) : err;

        done_now = r_done
                || (i_in.elapsed_ms >= i_cfg.time_limit_ms)
                || (mag <= ERR_W'(i_cfg.stop_tolerance));

        // add the error with saturation to the integral width
        int_max = {{(INT_SUM_W-INT_W+1){1'b0}}, {(INT_W-1){1'b1}}};
        int_min = {{(INT_SUM_W-INT_W+1){1'b1}}, {(INT_W-1){1'b0}}};
        int_sum = INT_SUM_W'(r_integral) + INT_SUM_W'(err);
        if (int_sum > int_max) begin
            int_sat = int_max[INT_W-1:0];
        end else if (int_sum < int_min) begin
            int_sat = int_min[INT_W-1:0];
        end else begin
            int_sat = int_sum[INT_W-1:0];
        end

        cap_ext = $signed({{(INT_W-LIM_W){1'b0}}, i_cfg.integral_cap});
        if (mag >= ERR_W'(i_cfg.integral_zone)) begin
            n_integral = '0;
        end else if (int_sat > cap_ext) begin
            n_integral = cap_ext;
        end else begin
            n_integral = int_sat;
        end

        n_term.err   = err;
        n_term.integ = n_integral;
        n_term.diff  = DIFF_W'(err) - DIFF_W'(r_prev_err);
        n_term.done  = done_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
            r_prev_err <= '0;
            r_done     <= 1'b0;
        end else if (i_en.take) begin
            r_done <= done_now;
            // a finished turn freezes the loop state
            if (!done_now) begin
                r_integral <= n_integral;
                r_prev_err <= err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_term <= n_term;
        end
    end

    assign o_term = r_term;

endmodule

[rtl/gtpc_drive.sv]
module gtpc_drive (
    input  logic               i_clk,
    input  gtpc_pkg::t_cfg     i_cfg,
    input  gtpc_pkg::t_pipe_en i_en,
    input  gtpc_pkg::t_term    i_term,
    output gtpc_pkg::t_out     o_out
);
    import gtpc_pkg::*;

    localparam logic signed [Q_W-1:0] Q_POS_LIM = Q_W'(128);
    localparam logic signed [Q_W-1:0] Q_NEG_LIM = -Q_POS_LIM;
    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = DRIVE_W'(127);

    logic signed [P_W-1:0]   r_p_term;
    logic signed [I_W-1:0]   r_i_term;
    logic signed [D_W-1:0]   r_d_term;
    logic                    r_done2;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_done3;
    t_out                    r_out;

    logic signed [GAIN_W:0]      kp;
    logic signed [GAIN_W:0]      ki;
    logic signed [GAIN_W:0]      kd;
    logic signed [Q_W-1:0]       q;
    logic                        round_up;
    logic signed [DRIVE_W-1:0]   power;
    t_out                        n_out;

    assign kp = $signed({1'b0, i_cfg.gain_p});
    assign ki = $signed({1'b0, i_cfg.gain_i});
    assign kd = $signed({1'b0, i_cfg.gain_d});

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_p_term <= P_W'(i_term.err) * P_W'(kp);
            r_i_term <= I_W'(i_term.integ) * I_W'(ki);
            r_d_term <= D_W'(i_term.diff) * D_W'(kd);
            r_done2  <= i_term.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_acc   <= ACC_W'(r_p_term) + ACC_W'(r_i_term) + ACC_W'(r_d_term);
            r_done3 <= r_done2;
        end
    end

    // divide by 256 toward zero: floor shift, then bump negatives with a remainder; clamp to +-127
    always_comb begin
        q        = r_acc[ACC_W-1:FRAC_W];
        round_up = r_acc[ACC_W-1] && (|r_acc[FRAC_W-1:0]);
        if (q >= Q_POS_LIM) begin
            power = DRIVE_MAX;
        end else if (q <= Q_NEG_LIM) begin
            power = -DRIVE_MAX;
        end else begin
            power = q[DRIVE_W-1:0] + DRIVE_W'(round_up);
        end

        if (r_done3) begin
            n_out.left_drive  = '0;
            n_out.right_drive = '0;
            n_out.finished    = 1'b1;
        end else begin
            n_out.left_drive  = -power;
            n_out.right_drive = power;
            n_out.finished    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.out) begin
            r_out <= n_out;
        end
    end

    assign o_out = r_out;

endmodule

[rtl/gyro_turn_pid_controller.sv]
// Gyro turn PID controller with integral zone.
// Input channel (i_in_valid / o_in_ready / i_in_data): one beat per gyro sample,
// carrying the heading and the milliseconds since the turn began.
// Output channel (o_out_valid / i_out_ready / o_out_data): one beat per input
// beat, in order: left and right drive (mirror images, saturated to +-127) and
// the finished flag. Once finished, every later beat reports zero drive.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx at the edge;
// write only while no beat is in flight.
// Throughput: one beat per cycle while the output is not stalled. The integral,
// previous error and done flag close their loop inside the first stage, so
// each sample sees the state left by the one before it at full rate.
// Pipeline: an accepted beat passes the input register, error/integral stage,
// multiply stage, sum stage and output register before o_out_valid rises.
// Stall: each stage holds only while the stage after it is full, so bubbles
// close up and o_in_ready drops only when all five registers hold beats.
// Reset: synchronous, active low; clears the pipeline, the loop state and the
// done flag, and loads the default gains and limits. A new turn needs a reset.
module gyro_turn_pid_controller (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  gtpc_pkg::t_in                   i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output gtpc_pkg::t_out                  o_out_data,
    input  logic                            i_cfg_we,
    input  logic [gtpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gtpc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import gtpc_pkg::*;

    t_cfg     cfg;
    t_in      r_in;
    t_term    term;
    t_pipe_en en;
    logic     en_in;
    logic     r_v0;
    logic     r_v1;
    logic     r_v2;
    logic     r_v3;
    logic     r_v_out;

    always_comb begin
        en.out = !r_v_out || i_out_ready;
        en.s3  = !r_v3 || en.out;
        en.s2  = !r_v2 || en.s3;
        en.s1  = !r_v1 || en.s2;
        en_in  = !r_v0 || en.s1;
        en.take = r_v0 && en.s1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v_out <= 1'b0;
        end else begin
            if (en_in) begin
                r_v0 <= i_in_valid;
            end
            if (en.s1) begin
                r_v1 <= r_v0;
            end
            if (en.s2) begin
                r_v2 <= r_v1;
            end
            if (en.s3) begin
                r_v3 <= r_v2;
            end
            if (en.out) begin
                r_v_out <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_in) begin
            r_in <= i_in_data;
        end
    end

    gtpc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    gtpc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (r_in),
        .i_en    (en),
        .o_term  (term)
    );

    gtpc_drive u_drive (
        .i_clk  (i_clk),
        .i_cfg  (cfg),
        .i_en   (en),
        .i_term (term),
        .o_out  (o_out_data)
    );

    assign o_in_ready  = en_in;
    assign o_out_valid = r_v_out;

`ifndef SYNTHESIS
    a_finished_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.finished |->
            o_out_data.left_drive == '0 && o_out_data.right_drive == '0)
        else $error("finished beat carries nonzero drive");

    a_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.left_drive == -o_out_data.right_drive
            && o_out_data.right_drive != -8'sd128)
        else $error("left and right drive not mirrored within range");

    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_v0 && r_v1 && r_v2 && r_v3 && r_v_out && !i_out_ready)
        else $error("input blocked while the pipeline has a free stage");

    a_state_moves_with_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en.take |-> r_v0 && en.s1)
        else $error("loop state updated without a beat leaving the input register");
`endif

endmodule
